FILE: rtl/rlwsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlwsc_pkg: shared types and constants for the remote link watchdog
// Item, result and configuration records, register indexes and reset values.
// ----------------------------------------------------------------------------
package rlwsc_pkg;

  // Configuration register indexes
  localparam logic CFG_REQ_EDGE_COUNT  = 1'b0;
  localparam logic CFG_GOOD_WIN_TARGET = 1'b1;

  localparam int CFG_DATA_W = 16;

  // Configuration reset values
  localparam logic [15:0] REQ_EDGE_COUNT_RST  = 16'd1;
  localparam logic [7:0]  GOOD_WIN_TARGET_RST = 8'd15;

  // Item kinds
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Saturation limits and the stop grade
  localparam logic [15:0] EDGE_COUNT_MAX = 16'hFFFF;
  localparam logic [7:0]  GOOD_RUN_MAX   = 8'hFF;
  localparam logic [1:0]  SPEED_STOP     = 2'd0;

  typedef struct packed {
    logic        kind;
    logic        forward_pin;
    logic [1:0]  speed_code;
    logic        over_current;
    logic        over_voltage;
  } rlwsc_item_t;

  typedef struct packed {
    logic        direction_forward;
    logic [1:0]  speed_grade;
    logic        link_lost;
    logic        link_established;
  } rlwsc_result_t;

  typedef struct packed {
    logic [15:0] required_edge_count;
    logic [7:0]  good_window_target;
  } rlwsc_cfg_t;

endpackage

FILE: rtl/rlwsc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlwsc_if: valid/ready channels of the remote link watchdog
// Command/tick input channel and status result channel.
// ----------------------------------------------------------------------------
interface rlwsc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic       forward_pin;
  logic [1:0] speed_code;
  logic       over_current;
  logic       over_voltage;

  modport source (output valid, kind, forward_pin, speed_code, over_current,
                  over_voltage, input ready);
  modport sink   (input valid, kind, forward_pin, speed_code, over_current,
                  over_voltage, output ready);
endinterface

interface rlwsc_out_if;
  logic       valid;
  logic       ready;
  logic       direction_forward;
  logic [1:0] speed_grade;
  logic       link_lost;
  logic       link_established;

  modport source (output valid, direction_forward, speed_grade, link_lost,
                  link_established, input ready);
  modport sink   (input valid, direction_forward, speed_grade, link_lost,
                  link_established, output ready);
endinterface

FILE: rtl/rlwsc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlwsc_cfg_regs: configuration registers
// Edge threshold per window and good-window target, written by index.
// ----------------------------------------------------------------------------
module rlwsc_cfg_regs
  import rlwsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output rlwsc_cfg_t            cfg
);

  logic [15:0] req_edge_r;
  logic [7:0]  target_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_edge_r <= REQ_EDGE_COUNT_RST;
      target_r   <= GOOD_WIN_TARGET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REQ_EDGE_COUNT:  req_edge_r <= cfg_wdata;
        CFG_GOOD_WIN_TARGET: target_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg.required_edge_count = req_edge_r;
  assign cfg.good_window_target  = target_r;

endmodule

FILE: rtl/rlwsc_link_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlwsc_link_core: link watchdog state and speed command update
// Applies one edge or tick per enabled cycle; presents the updated status.
// ----------------------------------------------------------------------------
module rlwsc_link_core
  import rlwsc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  rlwsc_item_t   item,
  input  rlwsc_cfg_t    cfg,
  output rlwsc_result_t res
);

  logic [15:0] edge_cnt_r, edge_cnt_nxt;
  logic [7:0]  run_r, run_nxt;
  logic        lost_r, lost_nxt;
  logic        est_r, est_nxt;
  logic        dir_r, dir_nxt;
  logic [1:0]  speed_r, speed_nxt;
  logic [7:0]  run_inc;
  logic        faults;

  assign faults  = item.over_current | item.over_voltage;
  assign run_inc = (run_r == GOOD_RUN_MAX) ? run_r : run_r + 8'd1;

  // Next state for the current item
  always_comb begin
    edge_cnt_nxt = edge_cnt_r;
    run_nxt      = run_r;
    lost_nxt     = lost_r;
    est_nxt      = est_r;
    dir_nxt      = dir_r;
    speed_nxt    = speed_r;
    if (item.kind == KIND_TICK) begin
      edge_cnt_nxt = '0;
      if (edge_cnt_r >= cfg.required_edge_count) begin
        lost_nxt = 1'b0;
        if (!est_r) begin
          run_nxt = run_inc;
          if (run_inc >= cfg.good_window_target) est_nxt = 1'b1;
        end
      end else begin
        lost_nxt  = 1'b1;
        est_nxt   = 1'b0;
        run_nxt   = '0;
        speed_nxt = SPEED_STOP;
      end
    end else begin
      if (edge_cnt_r != EDGE_COUNT_MAX) edge_cnt_nxt = edge_cnt_r + 16'd1;
      dir_nxt = item.forward_pin;
      // pins are active low: 11 stop .. 00 maximum
      if (!lost_r && !faults && est_r) speed_nxt = ~item.speed_code;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_cnt_r <= '0;
      run_r      <= '0;
      lost_r     <= 1'b0;
      est_r      <= 1'b0;
      dir_r      <= 1'b0;
      speed_r    <= SPEED_STOP;
    end else if (en) begin
      edge_cnt_r <= edge_cnt_nxt;
      run_r      <= run_nxt;
      lost_r     <= lost_nxt;
      est_r      <= est_nxt;
      dir_r      <= dir_nxt;
      speed_r    <= speed_nxt;
    end
  end

  assign res.direction_forward = dir_nxt;
  assign res.speed_grade       = speed_nxt;
  assign res.link_lost         = lost_nxt;
  assign res.link_established  = est_nxt;

  // Checks
  a_lost_not_est: assert property (@(posedge clk) disable iff (!rst_n)
    !(lost_r && est_r)) else $error("link both lost and established");

  a_lost_stops: assert property (@(posedge clk) disable iff (!rst_n)
    lost_r |-> (speed_r == SPEED_STOP)) else $error("speed not stop while lost");

  a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (en && item.kind == KIND_TICK) |=> (edge_cnt_r == '0))
    else $error("edge count not cleared by tick");

  a_speed_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (en && item.kind == KIND_EDGE && !est_r) |=> $stable(speed_r))
    else $error("speed changed without established link");

endmodule

FILE: rtl/remote_link_watchdog_speed_command.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_link_watchdog_speed_command: remote link watchdog and speed command
// Counts command edges per window, qualifies the link and latches commands.
// ----------------------------------------------------------------------------
// Each transaction on in_ch is a command edge or a window tick and yields
// exactly one status transaction on out_ch showing direction, speed grade and
// link state after that item. The block takes one transaction per cycle while
// out_ch accepts results, through an input register, then the state
// update feeding a result register. in_ch.ready stays high while the result
// register is free or being drained, so back-pressure on out_ch only stalls
// intake once both registers hold data. Configuration writes (cfg_index 0:
// required edge count, 1: good-window target) should be made while idle.
module remote_link_watchdog_speed_command
  import rlwsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  rlwsc_in_if.sink              in_ch,
  rlwsc_out_if.source           out_ch
);

  rlwsc_cfg_t    cfg;
  rlwsc_item_t   item_r;
  rlwsc_result_t res;
  rlwsc_result_t res_r;
  logic          in_vld_r;
  logic          out_vld_r;
  logic          advance;

  rlwsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rlwsc_link_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Pipeline flow control
  assign advance     = in_vld_r & (~out_vld_r | out_ch.ready);
  assign in_ch.ready = ~in_vld_r | advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.kind         <= in_ch.kind;
      item_r.forward_pin  <= in_ch.forward_pin;
      item_r.speed_code   <= in_ch.speed_code;
      item_r.over_current <= in_ch.over_current;
      item_r.over_voltage <= in_ch.over_voltage;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_ch.valid             = out_vld_r;
  assign out_ch.direction_forward = res_r.direction_forward;
  assign out_ch.speed_grade       = res_r.speed_grade;
  assign out_ch.link_lost         = res_r.link_lost;
  assign out_ch.link_established  = res_r.link_established;

endmodule

FILE: tb/remote_link_watchdog_speed_command_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_link_watchdog_speed_command_test: self-checking regression
// Drives command edges and window ticks through the valid/ready channels and
// checks each status transaction against a cycle-free model of the watchdog.
// Covers directed corner cases, the longest good-window run, back-pressure, and
// random windows across several edge-count thresholds and window targets.
// ----------------------------------------------------------------------------
module remote_link_watchdog_speed_command_test;
  import rlwsc_pkg::*;

  localparam int RESET_CYCLES  = 6;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int HOLD_CYCLES   = 200;
  localparam int REPORT_LIMIT  = 10;
  localparam int SETTLE_CYCLES = 4;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rlwsc_in_if  in_ch ();
  rlwsc_out_if out_ch ();

  remote_link_watchdog_speed_command dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model state: configuration copy and link status
  logic [15:0] min_edges     = REQ_EDGE_COUNT_RST;
  logic [7:0]  window_target = GOOD_WIN_TARGET_RST;
  logic [15:0] edges_seen    = '0;
  logic [7:0]  good_windows  = '0;
  logic        link_down     = 1'b0;
  logic        link_up       = 1'b0;
  logic        forward_q     = 1'b0;
  logic [1:0]  grade_q       = SPEED_STOP;

  rlwsc_result_t status_expected[$];
  rlwsc_result_t head_status;

  int error_count   = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Long receiver stall request: toggled by the test, serviced by the receiver
  logic hold_toggle = 1'b0;
  logic hold_ack    = 1'b0;
  int   hold_left   = 0;

  // Applies one item to the model, returns the status it should produce
  function automatic rlwsc_result_t advance_link_state(rlwsc_item_t it);
    rlwsc_result_t r;
    if (it.kind == KIND_TICK) begin
      if (edges_seen >= min_edges) begin
        link_down = 1'b0;
        if (!link_up) begin
          if (good_windows != GOOD_RUN_MAX) good_windows = good_windows + 8'd1;
          if (good_windows >= window_target) link_up = 1'b1;
        end
      end else begin
        link_down    = 1'b1;
        link_up      = 1'b0;
        good_windows = '0;
        grade_q      = SPEED_STOP;
      end
      edges_seen = '0;
    end else begin
      if (edges_seen != EDGE_COUNT_MAX) edges_seen = edges_seen + 16'd1;
      forward_q = it.forward_pin;
      // pins are active low: 11 stop ... 00 maximum
      if (!link_down && link_up && !(it.over_current || it.over_voltage))
        grade_q = 2'd3 - it.speed_code;
    end
    r.direction_forward = forward_q;
    r.speed_grade       = grade_q;
    r.link_lost         = link_down;
    r.link_established  = link_up;
    return r;
  endfunction

  function automatic rlwsc_item_t random_edge(int fault_pct);
    rlwsc_item_t it;
    it.kind         = KIND_EDGE;
    it.forward_pin  = 1'($urandom_range(1));
    it.speed_code   = 2'($urandom_range(3));
    it.over_current = ($urandom_range(99) < fault_pct);
    it.over_voltage = ($urandom_range(99) < fault_pct);
    return it;
  endfunction

  // Tick with junk in the ignored fields
  function automatic rlwsc_item_t random_tick();
    rlwsc_item_t it;
    it      = rlwsc_item_t'(6'($urandom));
    it.kind = KIND_TICK;
    return it;
  endfunction

  // One input transaction; the model is advanced on acceptance
  task automatic send_item(input rlwsc_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= it.kind;
    in_ch.forward_pin  <= it.forward_pin;
    in_ch.speed_code   <= it.speed_code;
    in_ch.over_current <= it.over_current;
    in_ch.over_voltage <= it.over_voltage;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    status_expected.push_back(advance_link_state(it));
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (status_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes only once the block is idle
  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
    wait_results_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_REQ_EDGE_COUNT) min_edges = data;
    else window_target = data[7:0];
    @(posedge clk);
  endtask

  task automatic test_directed_cases();
    // edge before the link is up: direction only
    send_item(rlwsc_item_t'{KIND_EDGE, 1'b1, 2'd0, 1'b1, 1'b1});
    send_item(rlwsc_item_t'{KIND_TICK, 1'b1, 2'd3, 1'b1, 1'b1});
    // target of zero and threshold of zero: first window establishes
    write_reg(CFG_REQ_EDGE_COUNT, 16'h0000);
    write_reg(CFG_GOOD_WIN_TARGET, 16'hA500);
    send_item(rlwsc_item_t'{KIND_TICK, 1'b0, 2'd0, 1'b0, 1'b0});
    // every speed decode, then faults blocking updates
    send_item(rlwsc_item_t'{KIND_EDGE, 1'b0, 2'd0, 1'b0, 1'b0});
    send_item(rlwsc_item_t'{KIND_EDGE, 1'b1, 2'd3, 1'b0, 1'b0});
    send_item(rlwsc_item_t'{KIND_EDGE, 1'b1, 2'd2, 1'b0, 1'b0});
    send_item(rlwsc_item_t'{KIND_EDGE, 1'b0, 2'd1, 1'b0, 1'b0});
    send_item(rlwsc_item_t'{KIND_EDGE, 1'b1, 2'd0, 1'b1, 1'b0});
    send_item(rlwsc_item_t'{KIND_EDGE, 1'b0, 2'd0, 1'b0, 1'b1});
    // good window while already established
    send_item(rlwsc_item_t'{KIND_TICK, 1'b1, 2'd3, 1'b1, 1'b1});
    // unreachable threshold: link lost, speed forced to stop
    write_reg(CFG_REQ_EDGE_COUNT, EDGE_COUNT_MAX);
    send_item(rlwsc_item_t'{KIND_TICK, 1'b0, 2'd1, 1'b0, 1'b1});
    send_item(rlwsc_item_t'{KIND_EDGE, 1'b1, 2'd0, 1'b0, 1'b0});
    // recover with a one-window target
    write_reg(CFG_REQ_EDGE_COUNT, 16'h0001);
    write_reg(CFG_GOOD_WIN_TARGET, 16'h5A01);
    send_item(rlwsc_item_t'{KIND_EDGE, 1'b0, 2'd2, 1'b0, 1'b0});
    send_item(rlwsc_item_t'{KIND_TICK, 1'b0, 2'd2, 1'b1, 1'b0});
    send_item(rlwsc_item_t'{KIND_EDGE, 1'b1, 2'd0, 1'b0, 1'b0});
    send_item(rlwsc_item_t'{KIND_TICK, 1'b1, 2'd0, 1'b0, 1'b0});
    wait_results_drained();
  endtask

  // Longest target: 255 good windows in a row
  task automatic test_good_run_limit();
    write_reg(CFG_REQ_EDGE_COUNT, EDGE_COUNT_MAX);
    send_item(random_tick());
    write_reg(CFG_REQ_EDGE_COUNT, 16'h0000);
    write_reg(CFG_GOOD_WIN_TARGET, {8'($urandom), GOOD_RUN_MAX});
    repeat (260) begin
      if ($urandom_range(3) == 0) send_item(random_edge(20));
      send_item(random_tick());
    end
    wait_results_drained();
  endtask

  // Windows one edge short of and exactly at a larger threshold
  task automatic test_large_threshold();
    write_reg(CFG_REQ_EDGE_COUNT, 16'd64);
    write_reg(CFG_GOOD_WIN_TARGET, 16'h0001);
    repeat (63) send_item(random_edge(10));
    send_item(random_tick());
    repeat (64) send_item(random_edge(10));
    send_item(random_tick());
    repeat (4) send_item(random_edge(0));
    send_item(random_tick());
    wait_results_drained();
  endtask

  // Receiver stalls long enough for the block to fill and stall its input
  task automatic test_backpressure_hold();
    write_reg(CFG_REQ_EDGE_COUNT, 16'h0001);
    write_reg(CFG_GOOD_WIN_TARGET, 16'h0002);
    repeat (8) send_item(random_edge(10));
    send_item(random_tick());
    hold_toggle <= ~hold_toggle;
    repeat (6) begin
      repeat (4) send_item(random_edge(10));
      send_item(random_tick());
    end
    // sender pauses until everything is out
    wait_results_drained();
    repeat (3) begin
      repeat (2) send_item(random_edge(10));
      send_item(random_tick());
    end
    wait_results_drained();
  endtask

  // Random windows around the threshold, plus some unstructured noise
  task automatic test_random_windows(input int n_items);
    int          sent;
    int          pick;
    int          n_edges;
    int          fault_pct;
    logic [15:0] thr;
    logic [7:0]  tgt;
    sent = 0;
    pick = $urandom_range(9);
    if (pick < 6) thr = 16'($urandom_range(4));
    else if (pick == 6) thr = 16'h0000;
    else if (pick == 7) thr = 16'($urandom_range(12, 5));
    else if (pick == 8) thr = 16'($urandom);
    else thr = EDGE_COUNT_MAX;
    pick = $urandom_range(9);
    if (pick < 7) tgt = 8'($urandom_range(4, 1));
    else if (pick == 7) tgt = 8'($urandom_range(255, 5));
    else if (pick == 8) tgt = GOOD_RUN_MAX;
    else tgt = 8'd1;
    write_reg(CFG_REQ_EDGE_COUNT, thr);
    write_reg(CFG_GOOD_WIN_TARGET, {8'($urandom), tgt});
    fault_pct = $urandom_range(25, 5);
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_item(rlwsc_item_t'(6'($urandom)));
        sent++;
      end else begin
        if (thr > 16'd20) n_edges = $urandom_range(6);
        else n_edges = int'(thr) + int'($urandom_range(3)) - 1;
        if (thr != 16'd0 && $urandom_range(7) == 0) n_edges = int'(thr) - 1;
        if (n_edges < 0) n_edges = 0;
        repeat (n_edges) send_item(random_edge(fault_pct));
        send_item(random_tick());
        sent += n_edges + 1;
      end
    end
    wait_results_drained();
  endtask

  // Receiver: check each status transaction, then choose next ready
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (status_expected.size() == 0) begin
        if (error_count < REPORT_LIMIT)
          $display("unexpected status transaction: dir=%0b speed=%0d lost=%0b est=%0b",
                   out_ch.direction_forward, out_ch.speed_grade, out_ch.link_lost,
                   out_ch.link_established);
        error_count++;
      end else begin
        head_status = status_expected.pop_front();
        if (out_ch.direction_forward !== head_status.direction_forward ||
            out_ch.speed_grade !== head_status.speed_grade ||
            out_ch.link_lost !== head_status.link_lost ||
            out_ch.link_established !== head_status.link_established) begin
          if (error_count < REPORT_LIMIT)
            $display({"status mismatch: exp dir=%0b speed=%0d lost=%0b est=%0b, ",
                      "got dir=%0b speed=%0d lost=%0b est=%0b"},
                     head_status.direction_forward, head_status.speed_grade,
                     head_status.link_lost, head_status.link_established,
                     out_ch.direction_forward, out_ch.speed_grade,
                     out_ch.link_lost, out_ch.link_established);
          error_count++;
        end
      end
    end
    if (hold_toggle != hold_ack) begin
      hold_ack     <= hold_toggle;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("remote_link_watchdog_speed_command regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_REQ_EDGE_COUNT;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_EDGE;
    in_ch.forward_pin  = 1'b0;
    in_ch.speed_code   = 2'd0;
    in_ch.over_current = 1'b0;
    in_ch.over_voltage = 1'b0;
    out_ch.ready       = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles lightly, receiver heavily
    send_idle_pct = 20;
    recv_idle_pct = 67;
    test_directed_cases();
    repeat (2) test_random_windows(100);
    test_good_run_limit();

    // the other way round
    send_idle_pct = 67;
    recv_idle_pct = 20;
    test_backpressure_hold();
    repeat (2) test_random_windows(100);

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) test_random_windows(100);
    test_large_threshold();

    wait_results_drained();
    if (error_count == 0) begin
      $display("remote_link_watchdog_speed_command regression: pass");
    end else begin
      $display("remote_link_watchdog_speed_command regression: fail");
    end
    $finish;
  end

endmodule
